// ----- rtl/core/gbdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gbdc_pkg;

  // Weighted luma sum, 300*r + 590*g + 110*b, peaks at 255000
  localparam int unsigned SUM_W = 18;

  localparam logic [SUM_W-1:0] COEF_R   = 18'd300;
  localparam logic [SUM_W-1:0] COEF_G   = 18'd590;
  localparam logic [SUM_W-1:0] COEF_B   = 18'd110;
  localparam logic [SUM_W-1:0] GRAY_DIV = 18'd1000;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [PIX_W-1:0] PIX_WHITE    = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK    = 8'h00;
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_THR = 2'd1;

  localparam logic [PIX_W-1:0] BIN_THR_RST = 8'd127;
  localparam logic [PCT_W-1:0] PCT_THR_RST = 7'd50;

  // Smallest weighted sum whose gray level exceeds the threshold: (thr + 1) * 1000
  function automatic logic [SUM_W-1:0] white_limit(input logic [PIX_W-1:0] thr);
    logic [SUM_W-1:0] t;
    t = SUM_W'(thr) + SUM_W'(1);
    return SUM_W'(t * GRAY_DIV);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gray_binarize_dark_classifier.sv -----
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_blue, in_green, in_red, in_last_pixel
// out_      output     out_valid / out_stall out_bin_value, out_alpha_out,
//                                            out_verdict_valid, out_nearly_black, out_last_out
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// One pixel per clock while out_stall is low; after the input register each pixel passes the
// binarize, counters, products and output register stages before out_valid rises.
// The threshold compare runs on the weighted sum against a limit precomputed at config write.
// Reset is synchronous active low; it empties the pipeline, clears the counters and loads
// the default thresholds. A stalled output fills the empty stages behind it before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module gray_binarize_dark_classifier
  import gbdc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                   clk,
  input  wire                   rst_n,

  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [PIX_W-1:0]      in_blue,
  input  wire  [PIX_W-1:0]      in_green,
  input  wire  [PIX_W-1:0]      in_red,
  input  wire                   in_last_pixel,

  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [PIX_W-1:0]      out_bin_value,
  output logic [PIX_W-1:0]      out_alpha_out,
  output logic                  out_verdict_valid,
  output logic                  out_nearly_black,
  output logic                  out_last_out,

  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned TOT_W  = COUNT_BITS + 1;
  localparam int unsigned PROD_W = COUNT_BITS + 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration
  logic [SUM_W-1:0] lim_r;
  logic [PCT_W-1:0] pct_r;

  // Pipeline valids and stage enables
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;

  // Stage 1: pixel
  logic [PIX_W-1:0] b1_r, g1_r, r1_r;
  logic             last1_r;
  logic [SUM_W-1:0] sum1;

  // Stage 2: binarized
  logic white2_r, last2_r;

  // Running counters
  logic [COUNT_BITS-1:0] black_r, white_r;
  logic [COUNT_BITS-1:0] black_inc, white_inc;
  logic [COUNT_BITS-1:0] black_nxt, white_nxt;

  // Stage 3: final counts
  logic                  white3_r, last3_r;
  logic [COUNT_BITS-1:0] black3_r;
  logic [TOT_W-1:0]      total3_r;

  // Stage 4: products
  logic              white4_r, last4_r, nz4_r;
  logic [PROD_W-1:0] black_pct4_r, thr_tot4_r;

  // Output register
  logic             bin_white_r, last_out_r, nearly_black_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= white_limit(BIN_THR_RST);
      pct_r <= PCT_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIN_THR: lim_r <= white_limit(cfg_wdata);
        REG_PCT_THR: pct_r <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on
  assign en_out   = !out_valid_r || !out_stall;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (en1) begin
      b1_r    <= in_blue;
      g1_r    <= in_green;
      r1_r    <= in_red;
      last1_r <= in_last_pixel;
    end
  end

  assign sum1 = SUM_W'(SUM_W'(r1_r) * COEF_R) + SUM_W'(SUM_W'(g1_r) * COEF_G)
              + SUM_W'(SUM_W'(b1_r) * COEF_B);

  // Stage 2
  always_ff @(posedge clk) begin
    if (en2) begin
      white2_r <= (sum1 >= lim_r);
      last2_r  <= last1_r;
    end
  end

  // Saturating counts including the current pixel
  assign black_inc = (black_r == CNT_MAX) ? CNT_MAX : black_r + COUNT_BITS'(1);
  assign white_inc = (white_r == CNT_MAX) ? CNT_MAX : white_r + COUNT_BITS'(1);
  assign black_nxt = white2_r ? black_r : black_inc;
  assign white_nxt = white2_r ? white_inc : white_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '0;
      white_r <= '0;
    end else if (v2_r && en3) begin
      // clear after the last pixel of an image
      black_r <= last2_r ? '0 : black_nxt;
      white_r <= last2_r ? '0 : white_nxt;
    end
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (en3) begin
      white3_r <= white2_r;
      last3_r  <= last2_r;
      black3_r <= black_nxt;
      total3_r <= TOT_W'(black_nxt) + TOT_W'(white_nxt);
    end
  end

  // Stage 4
  always_ff @(posedge clk) begin
    if (en4) begin
      white4_r     <= white3_r;
      last4_r      <= last3_r;
      nz4_r        <= (total3_r != '0);
      black_pct4_r <= PROD_W'(PROD_W'(black3_r) * PROD_W'(PCT_SCALE));
      thr_tot4_r   <= PROD_W'(PROD_W'(pct_r) * PROD_W'(total3_r));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      bin_white_r    <= white4_r;
      last_out_r     <= last4_r;
      nearly_black_r <= last4_r && nz4_r && (black_pct4_r >= thr_tot4_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_value     = bin_white_r ? PIX_WHITE : PIX_BLACK;
  assign out_alpha_out     = ALPHA_OPAQUE;
  assign out_verdict_valid = last_out_r;
  assign out_last_out      = last_out_r;
  assign out_nearly_black  = nearly_black_r;

endmodule

`default_nettype wire

// ----- rtl/core/gbdc_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbdc_check
  import gbdc_pkg::*;
(
  input wire             clk,
  input wire             rst_n,
  input wire             out_valid,
  input wire             out_stall,
  input wire [PIX_W-1:0] out_bin_value,
  input wire [PIX_W-1:0] out_alpha_out,
  input wire             out_verdict_valid,
  input wire             out_nearly_black,
  input wire             out_last_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_value)
      && $stable(out_nearly_black) && $stable(out_last_out))
    else $error("stalled result changed");

  a_bin_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bin_value == PIX_WHITE || out_bin_value == PIX_BLACK))
    else $error("binarized value not black or white");

  a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nearly_black |-> out_verdict_valid && out_last_out)
    else $error("verdict outside last pixel");

  a_verdict_valid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict_valid == out_last_out))
    else $error("verdict valid differs from last mark");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha_out == ALPHA_OPAQUE))
    else $error("alpha not opaque");

endmodule

bind gray_binarize_dark_classifier gbdc_check u_gbdc_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_bin_value     (out_bin_value),
  .out_alpha_out     (out_alpha_out),
  .out_verdict_valid (out_verdict_valid),
  .out_nearly_black  (out_nearly_black),
  .out_last_out      (out_last_out)
);

`default_nettype wire
